FILE: rtl/palette_color_resolver_macros.svh
// ----------------------------------------------------------------------------
// palette_color_resolver_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef PALETTE_COLOR_RESOLVER_MACROS_SVH
`define PALETTE_COLOR_RESOLVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PRC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Types and constants shared by the palette resolver controller and datapath.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int unsigned COLOR_W = 24;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned DIST_W  = 18;

  // One above the largest squared distance, so any entry beats it.
  localparam logic [DIST_W-1:0] BEST_INIT   = DIST_W'(3 * 255 * 255 + 1);
  localparam logic [IDX_W-1:0]  SLOT_OFFSET = IDX_W'(32);

  typedef struct packed {
    logic load;      // latch request, restart scan
    logic rd_en;     // issue palette read at scan pointer
    logic out_load;  // resolve and load output register
  } cmd_t;

  typedef struct packed {
    logic issue_more;  // scan pointer below fill count
    logic rd_valid;    // read data valid this cycle
    logic match;       // current read data equals request
    logic found;       // exact match already captured
  } stat_t;

endpackage

FILE: rtl/prc_ctrl.sv
// ----------------------------------------------------------------------------
// prc_ctrl
// Sequencer for request accept, palette scan and result hand-off.
// ----------------------------------------------------------------------------
module prc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  prc_pkg::stat_t stat,
  output prc_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;
  logic       scan_done;

  assign out_free  = !out_valid || out_ready;
  assign scan_done = !stat.rd_valid && (!stat.issue_more || stat.found);
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = stat.issue_more && !stat.found && !stat.match;
        if (scan_done) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/prc_datapath.sv
// ----------------------------------------------------------------------------
// prc_datapath
// Palette memory, fill count, distance unit, best tracker and result register.
// ----------------------------------------------------------------------------
module prc_datapath #(
  parameter int unsigned PALETTE_SIZE = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  prc_pkg::cmd_t                 cmd,
  output prc_pkg::stat_t                stat,
  input  logic [7:0]                    red_in,
  input  logic [7:0]                    green_in,
  input  logic [7:0]                    blue_in,
  output logic [prc_pkg::IDX_W-1:0]     slot_code,
  output logic                          is_new
);

  localparam int unsigned AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int unsigned FW = $clog2(PALETTE_SIZE + 1);

  logic [prc_pkg::COLOR_W-1:0] mem [PALETTE_SIZE];

  logic [7:0]                  req_r, req_g, req_b;
  logic [FW-1:0]               fill_count;
  logic [FW-1:0]               issue_cnt;
  logic [prc_pkg::COLOR_W-1:0] rd_data;
  logic                        rd_valid;
  logic [AW-1:0]               rd_slot;
  logic [prc_pkg::DIST_W-1:0]  best;
  logic [AW-1:0]               best_slot;

  logic [7:0]                  dr, dg, db;
  logic [15:0]                 sq_r, sq_g, sq_b;
  logic [prc_pkg::DIST_W-1:0]  sq_dist;
  logic                        full;

  // squared RGB distance of the entry just read
  always_comb begin
    dr   = (rd_data[23:16] > req_r) ? rd_data[23:16] - req_r : req_r - rd_data[23:16];
    dg   = (rd_data[15:8]  > req_g) ? rd_data[15:8]  - req_g : req_g - rd_data[15:8];
    db   = (rd_data[7:0]   > req_b) ? rd_data[7:0]   - req_b : req_b - rd_data[7:0];
    sq_r = 16'(dr) * 16'(dr);
    sq_g = 16'(dg) * 16'(dg);
    sq_b = 16'(db) * 16'(db);
    sq_dist = prc_pkg::DIST_W'(sq_r) + prc_pkg::DIST_W'(sq_g) + prc_pkg::DIST_W'(sq_b);
  end

  assign full = (fill_count == FW'(PALETTE_SIZE));

  assign stat.issue_more = (issue_cnt < fill_count);
  assign stat.rd_valid   = rd_valid;
  assign stat.match      = rd_valid && (sq_dist == '0);
  assign stat.found      = (best == '0);

  // palette read port, registered
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[issue_cnt[AW-1:0]];
    end
    rd_slot <= issue_cnt[AW-1:0];
  end

  // palette write port: allocation of a fresh color
  always_ff @(posedge clk) begin
    if (cmd.out_load && !stat.found && !full) begin
      mem[fill_count[AW-1:0]] <= {req_r, req_g, req_b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      rd_valid   <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en;
      if (cmd.out_load && !stat.found && !full) begin
        fill_count <= fill_count + FW'(1);
      end
    end
  end

  // request latch, scan pointer and best tracker
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= red_in;
      req_g     <= green_in;
      req_b     <= blue_in;
      issue_cnt <= '0;
      best      <= prc_pkg::BEST_INIT;
      best_slot <= '0;
    end else begin
      if (cmd.rd_en) begin
        issue_cnt <= issue_cnt + FW'(1);
      end
      // strict compare keeps the lowest slot on ties
      if (rd_valid && (sq_dist < best)) begin
        best      <= sq_dist;
        best_slot <= rd_slot;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (stat.found || full) begin
        slot_code <= prc_pkg::IDX_W'(best_slot) + prc_pkg::SLOT_OFFSET;
        is_new    <= 1'b0;
      end else begin
        slot_code <= prc_pkg::IDX_W'(fill_count) + prc_pkg::SLOT_OFFSET;
        is_new    <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/palette_color_resolver.sv
// ----------------------------------------------------------------------------
// palette_color_resolver
// Resolves an RGB color to a palette slot: exact hit, new allocation or
// nearest entry by squared distance.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one request per handshake, 24-bit color in s_tdata.
//   Master channel m_*: one result per request, palette slot plus 32 in
//   m_tdata, allocation flag in m_tuser.
//   The block takes one request at a time. After accept it scans the filled
//   palette entries through a registered memory read, one entry per cycle,
//   and stops early on an exact hit. A request against F filled entries
//   issues F reads; once the last read data returns, a resolve step loads
//   the result into the output register. An exact hit at slot k reads no
//   slot above k. The scan rate is set by the single palette read port.
//   s_tready returns once the result is in the output register, so the next
//   request can be scanned while that result still waits to be taken. If the
//   receiver stalls, the finished decision is held until the output register
//   frees, and m_tdata/m_tuser hold steady while m_tvalid is high.
//   Reset empties the palette (fill count zero) and drops any pending result;
//   entries need no clearing since only filled slots are read.
//   Once full, the palette is never overwritten.
// ----------------------------------------------------------------------------
module palette_color_resolver #(
  parameter int unsigned PALETTE_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [8:0] slot_code, [15:9] zero
  output logic [0:0]  m_tuser    // [0] is_new
);

  prc_pkg::cmd_t  cmd;
  prc_pkg::stat_t stat;

  logic [prc_pkg::IDX_W-1:0] slot_code;
  logic                      is_new;

  // sequencer: accept, scan, hand-off
  prc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // palette store, distance unit and result register
  prc_datapath #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .red_in      (s_tdata[7:0]),
    .green_in    (s_tdata[15:8]),
    .blue_in     (s_tdata[23:16]),
    .slot_code   (slot_code),
    .is_new      (is_new)
  );

  assign m_tdata = {7'd0, slot_code};
  assign m_tuser = is_new;

endmodule

FILE: rtl/prc_checker.sv
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks for the palette resolver, bound to the top level.
// ----------------------------------------------------------------------------
`include "palette_color_resolver_macros.svh"

module prc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // a request keeps the block busy for at least the scan cycle
  `PRC_ASSERT_NEXT(a_busy_after_req, clk, rst, s_tvalid && s_tready, !s_tready)

  // stalled result holds
  `PRC_ASSERT_NEXT(a_hold_on_stall, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // padding bits above the slot index stay clear
  `PRC_ASSERT_SAME(a_pad_zero, clk, rst, m_tvalid, m_tdata[15:9] == 7'd0)

endmodule

bind palette_color_resolver prc_checker u_prc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: sim/palette_color_resolver_test.sv
// ----------------------------------------------------------------------------
// palette_color_resolver_test
// Self-checking bench for the palette resolver. Requests come from a queue
// that an initial block fills phase by phase. A clocked driver presents them
// with random sender gaps, and a clocked monitor takes results with random
// receiver stalls. Each accepted color goes through a behavioral palette
// model. The model predicts the slot and the allocation flag, and every
// result is checked against the oldest prediction. The run fills the palette,
// then keeps resolving nearest colors against the full table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module palette_color_resolver_test;

  localparam int unsigned PALETTE_SLOTS = 256;
  localparam int unsigned SLOT_BASE     = 32;
  localparam int unsigned FAR_DIST      = 3 * 255 * 255;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_CYCLES  = 300;  // > one full-palette scan

  typedef struct packed {
    logic [8:0] slot_code;
    logic       is_new;
  } resolve_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;   // [8:0] slot_code, [15:9] zero
  logic [0:0]  m_tuser;   // [0] is_new

  // Palette model state
  logic [23:0] palette_model [PALETTE_SLOTS];
  int unsigned fill_model = 0;

  logic [23:0] pending_colors [$];
  logic [23:0] sent_colors [$];
  resolve_t    expected_results [$];

  int unsigned req_queued = 0;
  int unsigned req_accepted = 0;
  int unsigned res_checked = 0;
  int unsigned alloc_count = 0;
  int unsigned hit_count = 0;
  int unsigned nearest_count = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  logic        req_taken = 1'b0;

  palette_color_resolver #(
    .PALETTE_SIZE(PALETTE_SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  function automatic logic [23:0] rgb(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    return {b, g, r};
  endfunction

  // Scan filled slots in order: exact hit ends the scan, otherwise allocate
  // while room remains, otherwise nearest entry with the lowest slot on ties.
  function automatic resolve_t resolve_color(input logic [23:0] req);
    resolve_t    res;
    int          dr, dg, db, sq_dist, best_dist;
    int unsigned best_slot;
    best_dist = FAR_DIST + 1;
    best_slot = 0;
    for (int unsigned slot = 0; slot < fill_model; slot++) begin
      dr      = int'(palette_model[slot][7:0])   - int'(req[7:0]);
      dg      = int'(palette_model[slot][15:8])  - int'(req[15:8]);
      db      = int'(palette_model[slot][23:16]) - int'(req[23:16]);
      sq_dist = dr * dr + dg * dg + db * db;
      if (sq_dist < best_dist) begin
        if (sq_dist == 0) begin
          hit_count++;
          res.slot_code = 9'(slot + SLOT_BASE);
          res.is_new    = 1'b0;
          return res;
        end
        best_dist = sq_dist;
        best_slot = slot;
      end
    end
    if (fill_model < PALETTE_SLOTS) begin
      palette_model[fill_model] = req;
      res.slot_code = 9'(fill_model + SLOT_BASE);
      res.is_new    = 1'b1;
      fill_model++;
      alloc_count++;
    end else begin
      res.slot_code = 9'(best_slot + SLOT_BASE);
      res.is_new    = 1'b0;
      nearest_count++;
    end
    return res;
  endfunction

  task automatic push_color(input logic [23:0] c);
    pending_colors.push_back(c);
    sent_colors.push_back(c);
    req_queued++;
  endtask

  // Mix of fresh colors (uniform, near an earlier color, or on the cube
  // corners/faces) and repeats of colors already sent.
  task automatic queue_phase(input int unsigned count, input int unsigned new_pct);
    logic [23:0] c;
    logic [23:0] base;
    int          ch;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(99) >= new_pct) begin
        c = sent_colors[$urandom_range(sent_colors.size() - 1)];
      end else begin
        case ($urandom_range(2))
          0: c = 24'($urandom);
          1: begin
            base = sent_colors[$urandom_range(sent_colors.size() - 1)];
            for (int k = 0; k < 3; k++) begin
              ch = int'(base[8*k +: 8]) + $urandom_range(6) - 3;
              if (ch < 0) ch = 0;
              if (ch > 255) ch = 255;
              c[8*k +: 8] = 8'(ch);
            end
          end
          default: begin
            for (int k = 0; k < 3; k++) begin
              case ($urandom_range(2))
                0: c[8*k +: 8] = 8'h00;
                1: c[8*k +: 8] = 8'hff;
                default: c[8*k +: 8] = 8'($urandom);
              endcase
            end
          end
        endcase
      end
      push_color(c);
    end
  endtask

  task automatic wait_drained;
    while (pending_colors.size() != 0 || req_accepted != req_queued ||
           expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Request driver: new item only once the current one is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (pending_colors.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        s_tdata  <= pending_colors.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Accepted request -> prediction
  always @(posedge clk) begin
    req_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      expected_results.push_back(resolve_color(s_tdata));
      req_accepted++;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    resolve_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result index=%0d is_new=%0d", $time,
                 m_tdata[8:0], m_tuser[0]);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[8:0] !== want.slot_code) begin
          $display("%0t: slot_code mismatch expected %0d actual %0d", $time,
                   want.slot_code, m_tdata[8:0]);
          error_count++;
        end
        if (m_tuser[0] !== want.is_new) begin
          $display("%0t: is_new mismatch expected %0d actual %0d", $time,
                   want.is_new, m_tuser[0]);
          error_count++;
        end
        res_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time,
               expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [23:0] c;
    logic [23:0] fresh [$];
    logic        dup;
    int unsigned missing;
    rst             = 1'b1;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty palette, extremes, exact hits, tie pair for later.
    push_color(rgb(8'h00, 8'h00, 8'h00));
    push_color(rgb(8'hff, 8'hff, 8'hff));
    push_color(rgb(8'h00, 8'h00, 8'h00));
    push_color(rgb(8'hff, 8'hff, 8'hff));
    push_color(rgb(8'hff, 8'h00, 8'h00));
    push_color(rgb(8'h00, 8'hff, 8'h00));
    push_color(rgb(8'h00, 8'h00, 8'hff));
    push_color(rgb(8'hff, 8'hff, 8'h00));
    push_color(rgb(8'h55, 8'haa, 8'h55));
    push_color(rgb(8'haa, 8'h55, 8'haa));
    push_color(rgb(8'd10, 8'd10, 8'd10));
    push_color(rgb(8'd12, 8'd10, 8'd10));
    push_color(rgb(8'hff, 8'h00, 8'h00));
    push_color(rgb(8'd12, 8'd10, 8'd10));
    push_color(rgb(8'h01, 8'h00, 8'h00));
    push_color(rgb(8'h00, 8'h00, 8'h01));
    push_color(rgb(8'h55, 8'haa, 8'h55));
    wait_drained();

    queue_phase(130, 85);
    wait_drained();

    sender_idle_pct = 70;
    queue_phase(120, 70);
    wait_drained();

    sender_idle_pct = 0;
    recv_stall_pct  = 70;
    queue_phase(120, 60);
    wait_drained();

    // Top up to a full palette with colors known to be absent.
    sender_idle_pct = 24;
    recv_stall_pct  = 24;
    while (fill_model + fresh.size() < PALETTE_SLOTS) begin
      c   = 24'($urandom);
      dup = 1'b0;
      for (int unsigned s = 0; s < fill_model; s++)
        if (palette_model[s] == c) dup = 1'b1;
      foreach (fresh[i])
        if (fresh[i] == c) dup = 1'b1;
      if (!dup) fresh.push_back(c);
    end
    foreach (fresh[i]) push_color(fresh[i]);
    // Full palette probes: equal distance to the tie pair, near and at the
    // white corner, cube center.
    push_color(rgb(8'd11, 8'd10, 8'd10));
    push_color(rgb(8'hfe, 8'hff, 8'hff));
    push_color(rgb(8'h80, 8'h80, 8'h80));
    push_color(rgb(8'hff, 8'hff, 8'hff));
    queue_phase(130, 60);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    missing = expected_results.size();
    if (missing != 0) begin
      $display("%0t: %0d results never arrived", $time, missing);
    end

    $display("Checked %0d results of %0d requests: %0d allocations, %0d exact hits,",
             res_checked, req_accepted, alloc_count, hit_count);
    $display("%0d nearest lookups on a %0d-entry palette, %0d errors",
             nearest_count, fill_model, error_count + missing);
    if (error_count == 0 && missing == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/prc_pkg.sv
rtl/prc_ctrl.sv
rtl/prc_datapath.sv
rtl/palette_color_resolver.sv
rtl/prc_checker.sv
sim/palette_color_resolver_test.sv
